// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define HT_ASSERT(label, clk, rst_n, prop, msg)

`define HT_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/htach_pkg.sv =====
`timescale 1ns / 1ps

package htach_pkg;

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int TIME_W     = 64;
    localparam int PERIOD_W   = 32;
    localparam int MAG_W      = 8;
    localparam int PROD_W     = PERIOD_W + MAG_W;
    localparam int RPM_W      = 34;
    localparam int HZ_W       = 36;
    localparam int DIV_W      = 36;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int MUL_CNT_W  = $clog2(MAG_W);

    localparam logic [DIV_W-1:0] RPM_DIVIDEND = 36'd15360000000;
    localparam logic [DIV_W-1:0] HZ_DIVIDEND  = 36'd65536000000;

    localparam logic [31:0]      DEBOUNCE_RST   = 32'd1000;
    localparam logic [MAG_W-1:0] MAGNETS_RST    = 8'd1;
    localparam logic [31:0]      STOP_RST       = 32'd1500000;
    localparam logic [31:0]      MIN_PERIOD_RST = 32'd10000;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_MAGNETS    = 2'd1,
        REG_STOP       = 2'd2,
        REG_MIN_PERIOD = 2'd3
    } htach_reg_t;

    typedef struct packed {
        logic [31:0]      lockout_us;
        logic [MAG_W-1:0] pulses_per_rev;
        logic [31:0]      idle_limit_us;
        logic [31:0]      min_period_us;
    } htach_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_EDGE,
        ST_CHECK,
        ST_MUL,
        ST_CLAMP,
        ST_DIV,
        ST_DONE
    } htach_state_t;

endpackage

// ===== rtl/htach_regs.sv =====
`timescale 1ns / 1ps

module htach_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [htach_pkg::ADDR_W-1:0] paddr,
    input  logic [htach_pkg::DATA_W-1:0] pwdata,
    output logic [htach_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output htach_pkg::htach_cfg_t        cfg
);
    import htach_pkg::*;

    htach_cfg_t cfg_reg;
    htach_cfg_t cfg_next;
    htach_reg_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = htach_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_DEBOUNCE:   cfg_next.lockout_us     = pwdata;
                REG_MAGNETS:    cfg_next.pulses_per_rev = pwdata[MAG_W-1:0];
                REG_STOP:       cfg_next.idle_limit_us  = pwdata;
                REG_MIN_PERIOD: cfg_next.min_period_us  = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DEBOUNCE:   prdata = cfg_reg.lockout_us;
            REG_MAGNETS:    prdata = {{(DATA_W-MAG_W){1'b0}}, cfg_reg.pulses_per_rev};
            REG_STOP:       prdata = cfg_reg.idle_limit_us;
            REG_MIN_PERIOD: prdata = cfg_reg.min_period_us;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_us     <= DEBOUNCE_RST;
            cfg_reg.pulses_per_rev <= MAGNETS_RST;
            cfg_reg.idle_limit_us  <= STOP_RST;
            cfg_reg.min_period_us  <= MIN_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/htach_div.sv =====
`timescale 1ns / 1ps

module htach_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [htach_pkg::PERIOD_W-1:0] divisor,
    input  logic [htach_pkg::DIV_W-1:0]    dividend,
    output logic                           done,
    output logic [htach_pkg::DIV_W-1:0]    quotient
);
    import htach_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [PERIOD_W-1:0]  rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [PERIOD_W-1:0]  dvs_reg;
    logic [PERIOD_W-1:0]  dvs_next;
    logic [PERIOD_W:0]    trial;
    logic [PERIOD_W+1:0]  sub;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign sub      = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge       = !sub[PERIOD_W+1];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one quotient bit in per cycle
            rem_next  = ge ? sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            step_next = step_reg + DIV_CNT_W'(1);
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== rtl/hall_tachometer_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Handshake             Payload
// in       in_valid / in_stall   mode, time_us
// out      out_valid / out_stall rev_period, rpm_q8, hz_q16, valid_res, stale,
//                                edge_stamp, edge_total, update_time_us
// cfg      APB write/read        lockout, pulses per rev, idle limit, min period
//
// An edge transaction passes through ST_DIFF and ST_EDGE before the next acceptance.
// A read passes through ST_DIFF and ST_CHECK and ends there when the timeout test ends it;
// else it runs 8 shift-add multiply steps and ST_CLAMP, ends there for a zero period, and
// otherwise divides: the 36-step bit-serial dividers for rpm and hz run side by side.
// in_stall is high while a transaction is worked on; a finished read holds while
// the output register is full and stalled. Reset clears the edge history and out_valid.

module hall_tachometer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htach_pkg::ADDR_W-1:0]   paddr,
    input  logic [htach_pkg::DATA_W-1:0]   pwdata,
    output logic [htach_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [htach_pkg::TIME_W-1:0]   time_us,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [htach_pkg::PERIOD_W-1:0] rev_period,
    output logic [htach_pkg::RPM_W-1:0]    rpm_q8,
    output logic [htach_pkg::HZ_W-1:0]     hz_q16,
    output logic                           valid_res,
    output logic                           stale,
    output logic [htach_pkg::TIME_W-1:0]   edge_stamp,
    output logic [31:0]                    edge_total,
    output logic [htach_pkg::TIME_W-1:0]   update_time_us
);
    import htach_pkg::*;

    htach_cfg_t   cfg;
    htach_state_t state_reg;
    htach_state_t state_next;

    logic                 mode_reg;
    logic                 mode_next;
    logic [TIME_W-1:0]    time_reg;
    logic [TIME_W-1:0]    time_next;
    logic [TIME_W-1:0]    diff_reg;
    logic [TIME_W-1:0]    diff_next;
    logic [TIME_W-1:0]    prev_edge_reg;
    logic [TIME_W-1:0]    prev_edge_next;
    logic [PERIOD_W-1:0]  interval_reg;
    logic [PERIOD_W-1:0]  interval_next;
    logic [31:0]          count_reg;
    logic [31:0]          count_next;
    logic                 two_seen_reg;
    logic                 two_seen_next;
    logic                 vflag_reg;
    logic                 vflag_next;
    logic                 sflag_reg;
    logic                 sflag_next;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [PROD_W-1:0]    mcand_reg;
    logic [PROD_W-1:0]    mcand_next;
    logic [MAG_W-1:0]     mplier_reg;
    logic [MAG_W-1:0]     mplier_next;
    logic [MUL_CNT_W-1:0] mul_step_reg;
    logic [MUL_CNT_W-1:0] mul_step_next;
    logic [PERIOD_W-1:0]  period_reg;
    logic [PERIOD_W-1:0]  period_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_load;
    logic [PERIOD_W-1:0]  period_out_reg;
    logic [RPM_W-1:0]     rpm_out_reg;
    logic [HZ_W-1:0]      hz_out_reg;
    logic                 valid_out_reg;
    logic                 stale_out_reg;
    logic [TIME_W-1:0]    ref_out_reg;
    logic [31:0]          gen_out_reg;
    logic [TIME_W-1:0]    upd_out_reg;

    logic [PERIOD_W:0]    twice;
    logic [PERIOD_W:0]    limit;
    logic [MAG_W-1:0]     mag;
    logic [PERIOD_W-1:0]  period_calc;
    logic                 div_start;
    logic                 rpm_done;
    logic                 hz_done;
    logic [DIV_W-1:0]     rpm_quo;
    logic [DIV_W-1:0]     hz_quo;
    logic                 out_free;

    htach_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htach_div u_div_rpm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (period_calc),
        .dividend (RPM_DIVIDEND),
        .done     (rpm_done),
        .quotient (rpm_quo)
    );

    htach_div u_div_hz (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (period_calc),
        .dividend (HZ_DIVIDEND),
        .done     (hz_done),
        .quotient (hz_quo)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign twice    = {interval_reg, 1'b0};
    assign limit    = ({1'b0, cfg.idle_limit_us} > twice) ? {1'b0, cfg.idle_limit_us}
                                                          : twice;
    assign mag      = (cfg.pulses_per_rev == '0) ? MAG_W'(1) : cfg.pulses_per_rev;

    always_comb
    begin
        if (acc_reg < {{MAG_W{1'b0}}, cfg.min_period_us})
            period_calc = cfg.min_period_us;
        else if (|acc_reg[PROD_W-1:PERIOD_W])
            period_calc = '1;
        else
            period_calc = acc_reg[PERIOD_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        time_next      = time_reg;
        diff_next      = diff_reg;
        prev_edge_next = prev_edge_reg;
        interval_next  = interval_reg;
        count_next     = count_reg;
        two_seen_next  = two_seen_reg;
        vflag_next     = vflag_reg;
        sflag_next     = sflag_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        mul_step_next  = mul_step_reg;
        period_next    = period_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    time_next  = time_us;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                diff_next  = time_reg - prev_edge_reg;
                state_next = mode_reg ? ST_CHECK : ST_EDGE;
            end
            ST_EDGE:
            begin
                if (count_reg == '0)
                begin
                    prev_edge_next = time_reg;
                    count_next     = 32'd1;
                end
                else if (diff_reg >= {32'd0, cfg.lockout_us})
                begin
                    prev_edge_next = time_reg;
                    interval_next  = (|diff_reg[TIME_W-1:PERIOD_W]) ? '1
                                                                     : diff_reg[PERIOD_W-1:0];
                    count_next     = count_reg + 32'd1;
                    if (count_reg != '1)
                        two_seen_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                vflag_next = 1'b0;
                sflag_next = 1'b0;
                if (!two_seen_reg)
                begin
                    sflag_next = (count_reg == '0) || (diff_reg > {32'd0, cfg.idle_limit_us});
                    state_next = ST_DONE;
                end
                else if (diff_reg > {31'd0, limit})
                begin
                    sflag_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next      = '0;
                    mcand_next    = {{MAG_W{1'b0}}, interval_reg};
                    mplier_next   = mag;
                    mul_step_next = '0;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // add one partial product per cycle
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next    = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next   = {1'b0, mplier_reg[MAG_W-1:1]};
                mul_step_next = mul_step_reg + MUL_CNT_W'(1);
                if (mul_step_reg == MUL_CNT_W'(MAG_W - 1))
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (acc_reg == '0)
                begin
                    sflag_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    period_next = period_calc;
                    vflag_next  = 1'b1;
                    div_start   = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rpm_done && hz_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_edge_reg <= '0;
            interval_reg  <= '0;
            count_reg     <= '0;
            two_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_edge_reg <= prev_edge_next;
            interval_reg  <= interval_next;
            count_reg     <= count_next;
            two_seen_reg  <= two_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        time_reg     <= time_next;
        diff_reg     <= diff_next;
        vflag_reg    <= vflag_next;
        sflag_reg    <= sflag_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        mul_step_reg <= mul_step_next;
        period_reg   <= period_next;
        if (out_load)
        begin
            period_out_reg <= vflag_reg ? period_reg : '0;
            rpm_out_reg    <= vflag_reg ? rpm_quo[RPM_W-1:0] : '0;
            hz_out_reg     <= vflag_reg ? hz_quo : '0;
            valid_out_reg  <= vflag_reg;
            stale_out_reg  <= sflag_reg;
            ref_out_reg    <= prev_edge_reg;
            gen_out_reg    <= count_reg;
            upd_out_reg    <= time_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rev_period     = period_out_reg;
    assign rpm_q8         = rpm_out_reg;
    assign hz_q16         = hz_out_reg;
    assign valid_res      = valid_out_reg;
    assign stale          = stale_out_reg;
    assign edge_stamp     = ref_out_reg;
    assign edge_total     = gen_out_reg;
    assign update_time_us = upd_out_reg;

    `HT_ASSERT(a_div_done, clk, rst_n, rpm_done |-> (state_reg == ST_DIV), "stray divide done")
    `HT_ASSERT_NEVER(a_two_seen, clk, rst_n, $fell(two_seen_reg), "two-edge flag dropped")
    `HT_ASSERT(a_edge_src, clk, rst_n, !$stable(prev_edge_reg) |-> $past(state_reg == ST_EDGE), "stray edge")
    `HT_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "stray result")

endmodule

// ===== tb/sv/hall_tachometer_checker.sv =====
`timescale 1ns / 1ps

module hall_tachometer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [htach_pkg::ADDR_W-1:0]   paddr,
    input  logic [htach_pkg::DATA_W-1:0]   pwdata,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           mode,
    input  logic [htach_pkg::TIME_W-1:0]   time_us,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [htach_pkg::PERIOD_W-1:0] rev_period,
    input  logic [htach_pkg::RPM_W-1:0]    rpm_q8,
    input  logic [htach_pkg::HZ_W-1:0]     hz_q16,
    input  logic                           valid_res,
    input  logic                           stale,
    input  logic [htach_pkg::TIME_W-1:0]   edge_stamp,
    input  logic [31:0]                    edge_total,
    input  logic [htach_pkg::TIME_W-1:0]   update_time_us,
    output int                             mismatches,
    output int                             readings_due
);

    import htach_pkg::*;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [RPM_W-1:0]    rpm;
        logic [HZ_W-1:0]     hz;
        logic                valid;
        logic                stale;
        logic [TIME_W-1:0]   ref_edge;
        logic [31:0]         generation;
        logic [TIME_W-1:0]   read_time;
    } tach_reading_t;

    htach_cfg_t          cfg;
    logic [TIME_W-1:0]   prev_edge;
    logic [31:0]         last_interval;
    logic [31:0]         edge_tally;
    logic                two_edges;
    tach_reading_t       pending_readings[$];
    int                  mismatch_count;

    function automatic tach_reading_t predict_reading(input logic [TIME_W-1:0] now);
        tach_reading_t r;
        logic [63:0] since;
        logic [63:0] limit;
        logic [63:0] twice;
        logic [63:0] mag;
        logic [63:0] span;
        logic [63:0] quot;
        r = '0;
        since = now - prev_edge;
        r.ref_edge = prev_edge;
        r.generation = edge_tally;
        r.read_time = now;
        if (!two_edges)
        begin
            r.stale = (edge_tally == 32'd0) || (since > {32'd0, cfg.idle_limit_us});
        end
        else
        begin
            limit = {32'd0, cfg.idle_limit_us};
            twice = {31'd0, last_interval, 1'b0};
            if (twice > limit)
                limit = twice;
            mag = (cfg.pulses_per_rev == '0) ? 64'd1 : {56'd0, cfg.pulses_per_rev};
            if (since > limit)
            begin
                r.stale = 1'b1;
            end
            else
            begin
                span = {32'd0, last_interval} * mag;
                if (span == 64'd0)
                begin
                    r.stale = 1'b1;
                end
                else
                begin
                    if (span < {32'd0, cfg.min_period_us})
                        span = {32'd0, cfg.min_period_us};
                    else if (span > 64'hFFFF_FFFF)
                        span = 64'hFFFF_FFFF;
                    r.period = span[PERIOD_W-1:0];
                    quot = {28'd0, RPM_DIVIDEND} / span;
                    r.rpm = quot[RPM_W-1:0];
                    quot = {28'd0, HZ_DIVIDEND} / span;
                    r.hz = quot[HZ_W-1:0];
                    r.valid = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void note_edge(input logic [TIME_W-1:0] now);
        logic [63:0] since;
        if (edge_tally != 32'd0)
        begin
            since = now - prev_edge;
            if (since >= {32'd0, cfg.lockout_us})
            begin
                prev_edge = now;
                last_interval = (since > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : since[31:0];
                edge_tally = edge_tally + 32'd1;
                if (edge_tally >= 32'd2)
                    two_edges = 1'b1;
            end
        end
        else
        begin
            prev_edge = now;
            edge_tally = 32'd1;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tach_reading_t want;
        if (!rst_n)
        begin
            cfg.lockout_us = DEBOUNCE_RST;
            cfg.pulses_per_rev = MAGNETS_RST;
            cfg.idle_limit_us = STOP_RST;
            cfg.min_period_us = MIN_PERIOD_RST;
            prev_edge = '0;
            last_interval = '0;
            edge_tally = '0;
            two_edges = 1'b0;
            pending_readings.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (htach_reg_t'(paddr[3:2]))
                    REG_DEBOUNCE:   cfg.lockout_us = pwdata;
                    REG_MAGNETS:    cfg.pulses_per_rev = pwdata[MAG_W-1:0];
                    REG_STOP:       cfg.idle_limit_us = pwdata;
                    REG_MIN_PERIOD: cfg.min_period_us = pwdata;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("reading transaction arrived with none expected");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    compare_field("rev_period", 64'(want.period), 64'(rev_period));
                    compare_field("rpm_q8", 64'(want.rpm), 64'(rpm_q8));
                    compare_field("hz_q16", 64'(want.hz), 64'(hz_q16));
                    compare_field("valid_res", 64'(want.valid), 64'(valid_res));
                    compare_field("stale", 64'(want.stale), 64'(stale));
                    compare_field("edge_stamp", want.ref_edge, edge_stamp);
                    compare_field("edge_total", 64'(want.generation), 64'(edge_total));
                    compare_field("update_time_us", want.read_time, update_time_us);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode)
                    pending_readings.push_back(predict_reading(time_us));
                else
                    note_edge(time_us);
            end
        end
        readings_due <= pending_readings.size();
        mismatches <= mismatch_count;
    end

endmodule

// ===== tb/sv/hall_tachometer_top_test.sv =====
`timescale 1ns / 1ps

module hall_tachometer_top_test;

    import htach_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE         = 60;
    localparam int END_SETTLE     = 100;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASES         = 7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic [TIME_W-1:0]     time_us;
    logic                  out_valid;
    logic                  out_stall;
    logic [PERIOD_W-1:0]   rev_period;
    logic [RPM_W-1:0]      rpm_q8;
    logic [HZ_W-1:0]       hz_q16;
    logic                  valid_res;
    logic                  stale;
    logic [TIME_W-1:0]     edge_stamp;
    logic [31:0]           edge_total;
    logic [TIME_W-1:0]     update_time_us;

    int mismatches;
    int readings_due;
    int quiet_cycles = 0;
    int send_gap_max = 9;
    int recv_gap_max = 9;
    bit hold_off_pending = 1'b0;

    always #5 clk = ~clk;

    hall_tachometer_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rev_period     (rev_period),
        .rpm_q8         (rpm_q8),
        .hz_q16         (hz_q16),
        .valid_res      (valid_res),
        .stale          (stale),
        .edge_stamp     (edge_stamp),
        .edge_total     (edge_total),
        .update_time_us (update_time_us)
    );

    hall_tachometer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .time_us        (time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rev_period     (rev_period),
        .rpm_q8         (rpm_q8),
        .hz_q16         (hz_q16),
        .valid_res      (valid_res),
        .stale          (stale),
        .edge_stamp     (edge_stamp),
        .edge_total     (edge_total),
        .update_time_us (update_time_us),
        .mismatches     (mismatches),
        .readings_due   (readings_due)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input htach_reg_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain(input int settle);
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] debounce, input logic [31:0] magnets,
                              input logic [31:0] idle_limit, input logic [31:0] min_period);
        in_valid <= 1'b0;
        drain(SETTLE);
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_MAGNETS, magnets);
        write_reg(REG_STOP, idle_limit);
        write_reg(REG_MIN_PERIOD, min_period);
    endtask

    task automatic send_item(input logic m, input logic [TIME_W-1:0] t);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        time_us <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // edges follow a rotation at the given beat; reads sample it in between
    task automatic spin_phase(input int count, input logic [31:0] beat);
        logic [TIME_W-1:0] now;
        int pick;
        if ($urandom_range(0, 3) == 0)
            now = {$urandom, $urandom};
        else
            now = {32'd0, 32'($urandom_range(0, 1000000))};
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_item(1'($urandom_range(0, 1)), {$urandom, $urandom});
            end
            else if (pick < 42)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(1'b1, now + {32'd0, $urandom});
                else
                    send_item(1'b1, now + {32'd0, 32'($urandom_range(0, 3 * beat))});
            end
            else
            begin
                if (pick < 50)
                    now = now + {32'd0, 32'($urandom_range(0, beat / 8))};
                else if (pick < 53)
                    now = now + {32'd0, $urandom};
                else if (pick < 55)
                    now = now - {32'd0, 32'($urandom_range(1, beat))};
                else
                    now = now + {32'd0, beat - beat / 16 + 32'($urandom_range(0, beat / 8))};
                send_item(1'b0, now);
            end
        end
    endtask

    initial
    begin
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold = LONG_HOLD;
            end
            else
            begin
                hold = $urandom_range(0, recv_gap_max);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [31:0] beat;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        mode <= 1'b0;
        time_us <= '0;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first edge, bounce, clamp, timeout, backwards time
        send_item(1'b1, 64'd0);
        send_item(1'b0, 64'd5000);
        send_item(1'b1, 64'd6000);
        send_item(1'b1, 64'd1505001);
        send_item(1'b0, 64'd5500);
        send_item(1'b0, 64'd25000);
        send_item(1'b1, 64'd30000);
        send_item(1'b0, 64'd28000);
        send_item(1'b1, 64'd29000);
        send_item(1'b1, 64'd1528001);
        send_item(1'b0, 64'd10);
        send_item(1'b1, 64'd20);
        send_item(1'b0, '1);
        send_item(1'b1, '1);

        // zero lockout, magnets zero, no clamp: zero period and fastest speed
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 64'd100);
        send_item(1'b0, 64'd100);
        send_item(1'b1, 64'd100);
        send_item(1'b0, 64'd101);
        send_item(1'b1, 64'd102);
        send_item(1'b1, 64'd103);
        send_item(1'b1, 64'd104);

        // every register at its top value
        set_config('1, 32'd255, '1, '1);
        send_item(1'b0, 64'd1000);
        send_item(1'b0, 64'h1_0000_0065);
        send_item(1'b1, 64'h1_0000_0065);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 3)
                0:       beat = $urandom_range(1, 200);
                1:       beat = $urandom_range(1000, 200000);
                default: beat = $urandom_range(1000000, 1000000000);
            endcase
            if (p == 5)
                set_config($urandom, $urandom, $urandom, $urandom);
            else
                set_config(($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(0, beat / 2)),
                           (p % 2 == 1) ? 32'($urandom_range(0, 255))
                                        : 32'($urandom_range(0, 4)),
                           $urandom_range(0, 3 * beat),
                           $urandom_range(0, 2 * beat));
            send_gap_max = (p == 0 || p == 2) ? 0 : 9;
            recv_gap_max = (p == 0 || p == 3) ? 0 : 9;
            if (p == 2)
                hold_off_pending = 1'b1;
            spin_phase(PHASE_ITEMS, beat);
        end

        in_valid <= 1'b0;
        drain(END_SETTLE);
        if (mismatches == 0 && readings_due == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
